@@ src/segment_tree_range_sum_core_assert.svh @@
// Assertion macros shared by the segment tree range sum core.
// No dependencies; included by the controller and the datapath.
`ifndef SEGMENT_TREE_RANGE_SUM_CORE_ASSERT_SVH
`define SEGMENT_TREE_RANGE_SUM_CORE_ASSERT_SVH

// Plain property, checked outside reset.
`define SEGTR_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error(msg);

// A condition in one cycle implies a consequence in the following cycle.
`define SEGTR_ASSERT_NEXT(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (conseq)) \
        else $error(msg);

`endif

@@ src/segtr_pkg.sv @@
// Package for the segment tree range sum core: field widths, word layout,
// opcodes and the command and status groups between controller and datapath.
`timescale 1ns / 1ps

package segtr_pkg;

    localparam int POS_W     = 11;
    localparam int VAL_W     = 64;
    localparam int SUM_W     = 64;

    // Input word layout, lowest bit first.
    localparam int POS_LSB   = 0;
    localparam int VAL_LSB   = POS_LSB + POS_W;
    localparam int LEFT_LSB  = VAL_LSB + VAL_W;
    localparam int RIGHT_LSB = LEFT_LSB + POS_W;
    localparam int FIELDS_W  = RIGHT_LSB + POS_W;
    localparam int S_TDATA_W = ((FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SUM_W + 7) / 8) * 8;

    typedef enum logic {
        OP_SET   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        logic clear_en;
        logic load_set;
        logic load_qry;
        logic elem_wr;
        logic upd_walk;
        logic qry_walk;
        logic qry_sub;
        logic lo_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic pos_ok;
        logic q_empty;
        logic idx_zero;
        logic idx_over;
    } sts_t;

endpackage

@@ src/segtr_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module segtr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/segtr_dpath.sv @@
// Datapath of the segment tree range sum core: element and tree memories,
// walk index, delta and accumulator. Uses segtr_pkg, segtr_ram and the assert header.
`timescale 1ns / 1ps
`include "segment_tree_range_sum_core_assert.svh"

module segtr_dpath #(
    parameter int NUM_ELEMENTS = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  segtr_pkg::cmd_t                      cmd,
    output segtr_pkg::sts_t                      sts,
    input  logic [segtr_pkg::POS_W-1:0]          position,
    input  logic signed [segtr_pkg::VAL_W-1:0]   new_value,
    input  logic [segtr_pkg::POS_W-1:0]          left_bound,
    input  logic [segtr_pkg::POS_W-1:0]          right_bound,
    output logic signed [segtr_pkg::SUM_W-1:0]   range_sum
);

    import segtr_pkg::*;

    localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int IW = $clog2(NUM_ELEMENTS + 1);
    localparam int XW = ((IW > POS_W) ? IW : POS_W) + 1;

    logic [XW-1:0]    idx_reg, idx_next;
    logic [XW-1:0]    lo_reg, lo_next;
    logic [VAL_W-1:0] new_reg, new_next;
    logic [VAL_W-1:0] delta_reg, delta_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [SUM_W-1:0] out_reg, out_next;
    logic [AW-1:0]    pend_addr_reg, pend_addr_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             pend_wr_reg, pend_wr_next;
    logic             pend_add_reg, pend_add_next;
    logic             pend_sub_reg, pend_sub_next;

    logic [XW-1:0]    lowbit;
    logic [XW-1:0]    idx_m1;
    logic [XW-1:0]    num_x;
    logic [XW-1:0]    left_x, right_x;
    logic [XW-1:0]    l_clamp, r_clamp;
    logic [XW-1:0]    pos_x;
    logic [AW-1:0]    rd_addr;
    logic [VAL_W-1:0] elem_rd, tree_rd;
    logic             elem_we, tree_we;
    logic [AW-1:0]    elem_waddr, tree_waddr;
    logic [VAL_W-1:0] elem_wdata, tree_wdata;

    assign num_x   = XW'(NUM_ELEMENTS);
    assign lowbit  = idx_reg & (~idx_reg + XW'(1));
    assign idx_m1  = idx_reg - XW'(1);
    assign rd_addr = idx_m1[AW-1:0];

    // Query bounds are clipped to the stored positions.
    assign pos_x   = XW'(position);
    assign left_x  = XW'(left_bound);
    assign right_x = XW'(right_bound);
    assign l_clamp = (left_x == '0) ? XW'(1) : left_x;
    assign r_clamp = (right_x > num_x) ? num_x : right_x;

    assign sts.clear_last = (clr_cnt_reg == AW'(NUM_ELEMENTS - 1));
    assign sts.pos_ok     = (pos_x != '0) && (pos_x <= num_x);
    assign sts.q_empty    = (l_clamp > r_clamp);
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.idx_over   = (idx_reg > num_x);

    assign elem_we    = cmd.clear_en | cmd.elem_wr;
    assign elem_waddr = cmd.clear_en ? clr_cnt_reg : rd_addr;
    assign elem_wdata = cmd.clear_en ? '0 : new_reg;

    assign tree_we    = cmd.clear_en | pend_wr_reg;
    assign tree_waddr = cmd.clear_en ? clr_cnt_reg : pend_addr_reg;
    assign tree_wdata = cmd.clear_en ? '0 : (tree_rd + delta_reg);

    segtr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NUM_ELEMENTS)
    ) u_elem_ram (
        .aclk    (aclk),
        .wr_en   (elem_we),
        .wr_addr (elem_waddr),
        .wr_data (elem_wdata),
        .rd_addr (rd_addr),
        .rd_data (elem_rd)
    );

    segtr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NUM_ELEMENTS)
    ) u_tree_ram (
        .aclk    (aclk),
        .wr_en   (tree_we),
        .wr_addr (tree_waddr),
        .wr_data (tree_wdata),
        .rd_addr (rd_addr),
        .rd_data (tree_rd)
    );

    always_comb begin
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        new_next       = new_reg;
        delta_next     = delta_reg;
        acc_next       = acc_reg;
        out_next       = out_reg;
        pend_addr_next = pend_addr_reg;
        clr_cnt_next   = clr_cnt_reg;

        if (cmd.clear_en) begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end

        if (cmd.load_set) begin
            idx_next = pos_x;
            new_next = new_value;
        end else if (cmd.load_qry) begin
            idx_next = r_clamp;
            lo_next  = l_clamp - XW'(1);
        end else if (cmd.lo_load) begin
            idx_next = lo_reg;
        end else if (cmd.upd_walk && !sts.idx_over) begin
            idx_next       = idx_reg + lowbit;
            pend_addr_next = rd_addr;
        end else if (cmd.qry_walk && !sts.idx_zero) begin
            idx_next = idx_reg - lowbit;
        end

        if (cmd.elem_wr) begin
            delta_next = new_reg - elem_rd;
        end

        // Read data arrives in the cycle after the index that addressed it.
        if (cmd.load_qry) begin
            acc_next = '0;
        end else if (pend_add_reg) begin
            acc_next = acc_reg + tree_rd;
        end else if (pend_sub_reg) begin
            acc_next = acc_reg - tree_rd;
        end

        if (cmd.out_load) begin
            out_next = acc_reg;
        end

        pend_wr_next  = cmd.upd_walk && !sts.idx_over;
        pend_add_next = cmd.qry_walk && !sts.idx_zero && !cmd.qry_sub;
        pend_sub_next = cmd.qry_walk && !sts.idx_zero && cmd.qry_sub;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            pend_wr_reg  <= 1'b0;
            pend_add_reg <= 1'b0;
            pend_sub_reg <= 1'b0;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            pend_wr_reg  <= pend_wr_next;
            pend_add_reg <= pend_add_next;
            pend_sub_reg <= pend_sub_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        lo_reg        <= lo_next;
        new_reg       <= new_next;
        delta_reg     <= delta_next;
        acc_reg       <= acc_next;
        out_reg       <= out_next;
        pend_addr_reg <= pend_addr_next;
    end

    assign range_sum = out_reg;

    `SEGTR_ASSERT(a_pend_excl, aclk, aresetn,
        $onehot0({pend_wr_reg, pend_add_reg, pend_sub_reg}),
        "segtr_dpath: more than one pending memory access kind")
    `SEGTR_ASSERT_NEXT(a_upd_rises, aclk, aresetn,
        cmd.upd_walk && !sts.idx_over && !cmd.load_set,
        idx_reg > $past(idx_reg),
        "segtr_dpath: update walk index did not climb")
    `SEGTR_ASSERT_NEXT(a_qry_falls, aclk, aresetn,
        cmd.qry_walk && !sts.idx_zero && !cmd.lo_load,
        idx_reg < $past(idx_reg),
        "segtr_dpath: query walk index did not descend")

endmodule

@@ src/segtr_ctrl.sv @@
// Controller of the segment tree range sum core: clearing pass, item
// sequencing and the output valid flag. Uses segtr_pkg and the assert header.
`timescale 1ns / 1ps
`include "segment_tree_range_sum_core_assert.svh"

module segtr_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  segtr_pkg::op_t  op,
    output logic            m_tvalid,
    input  logic            m_tready,
    output segtr_pkg::cmd_t cmd,
    input  segtr_pkg::sts_t sts
);

    import segtr_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR     = 8'b0000_0001,
        ST_IDLE      = 8'b0000_0010,
        ST_SET_RD    = 8'b0000_0100,
        ST_SET_DELTA = 8'b0000_1000,
        ST_UPD_WALK  = 8'b0001_0000,
        ST_QRY_HI    = 8'b0010_0000,
        ST_QRY_LO    = 8'b0100_0000,
        ST_QRY_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (op == OP_SET) begin
                        if (sts.pos_ok) begin
                            cmd.load_set = 1'b1;
                            state_next   = ST_SET_RD;
                        end
                    end else begin
                        cmd.load_qry = 1'b1;
                        state_next   = sts.q_empty ? ST_QRY_DONE : ST_QRY_HI;
                    end
                end
            end
            ST_SET_RD: begin
                state_next = ST_SET_DELTA;
            end
            ST_SET_DELTA: begin
                cmd.elem_wr = 1'b1;
                state_next  = ST_UPD_WALK;
            end
            ST_UPD_WALK: begin
                cmd.upd_walk = 1'b1;
                if (sts.idx_over) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QRY_HI: begin
                cmd.qry_walk = 1'b1;
                if (sts.idx_zero) begin
                    cmd.lo_load = 1'b1;
                    state_next  = ST_QRY_LO;
                end
            end
            ST_QRY_LO: begin
                cmd.qry_walk = 1'b1;
                cmd.qry_sub  = 1'b1;
                if (sts.idx_zero) begin
                    state_next = ST_QRY_DONE;
                end
            end
            ST_QRY_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign m_tvalid_next = (m_tvalid_reg && !m_tready) || cmd.out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `SEGTR_ASSERT(a_out_free, aclk, aresetn,
        !cmd.out_load || !m_tvalid_reg || m_tready,
        "segtr_ctrl: result loaded over a word not yet taken")
    `SEGTR_ASSERT_NEXT(a_bad_set_dropped, aclk, aresetn,
        accept && (op == OP_SET) && !sts.pos_ok,
        state_reg == ST_IDLE,
        "segtr_ctrl: set to an out-of-range position was not dropped")
    `SEGTR_ASSERT_NEXT(a_clear_done, aclk, aresetn,
        (state_reg == ST_CLEAR) && sts.clear_last,
        s_tready,
        "segtr_ctrl: input not opened after the clearing pass")

endmodule

@@ src/segment_tree_range_sum_core.sv @@
// Top level of the segment tree range sum core: stream ports, word unpacking
// and the controller/datapath pair. Uses segtr_pkg, segtr_ctrl and segtr_dpath.
`timescale 1ns / 1ps

// Channel   Direction  Word contents                                    Ends after
// s_        in         set an element or ask for a range sum            one word per item
// m_        out        wrapped 64-bit range sum                         one word per query
//
// After reset a clearing pass writes zero to every element and tree entry, one
// entry per cycle, and input opens only once that pass has finished.
// A set word has its old element read and the delta to the new value formed;
// the delta is then added to each tree entry on its upward walk (at most
// log2(NUM_ELEMENTS) + 1 entries); each walk step is one memory read.
// A query walks the set bits of the clipped upper prefix index, adding, then
// those of the lower prefix index, subtracting; an empty range skips both walks.
// A finished sum sits in the output register while the next word is taken.

module segment_tree_range_sum_core #(
    parameter int NUM_ELEMENTS = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input channel.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // position[10:0], new_value[74:11], left_bound[85:75], right_bound[96:86],
    // zero padding[103:97].
    input  logic [segtr_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[0]: 0 sets an element, 1 asks for a range sum.
    input  logic [0:0]                       s_tuser,
    // Result channel.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // range_sum[63:0].
    output logic [segtr_pkg::M_TDATA_W-1:0]  m_tdata
);

    import segtr_pkg::*;

    cmd_t                     cmd;
    sts_t                     sts;
    op_t                      op;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  new_value;
    logic [POS_W-1:0]         left_bound;
    logic [POS_W-1:0]         right_bound;
    logic signed [SUM_W-1:0]  range_sum;

    // Unpack the input word into its fields.
    assign op          = op_t'(s_tuser[0]);
    assign position    = s_tdata[POS_LSB +: POS_W];
    assign new_value   = s_tdata[VAL_LSB +: VAL_W];
    assign left_bound  = s_tdata[LEFT_LSB +: POS_W];
    assign right_bound = s_tdata[RIGHT_LSB +: POS_W];

    // The controller sequences the clearing pass, the set and query walks
    // and the output hand-over.
    segtr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath keeps the elements and a binary indexed sum tree, whose
    // prefix sums give any inclusive range as the difference of two prefixes.
    segtr_dpath #(
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .position    (position),
        .new_value   (new_value),
        .left_bound  (left_bound),
        .right_bound (right_bound),
        .range_sum   (range_sum)
    );

    assign m_tdata = M_TDATA_W'(range_sum);

endmodule

@@ tb/segtr_sum_checker.sv @@
// Checker for the segment tree range sum core: watches both stream channels,
// keeps a shadow copy of the elements and compares every returned sum.
// Depends on segtr_pkg for the word layout and the opcodes.
`timescale 1ns / 1ps

module segtr_sum_checker #(
    parameter int NUM_ELEMENTS = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [segtr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [segtr_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                               fail_count,
    output int                               pending
);
    import segtr_pkg::*;

    logic [VAL_W-1:0] element_shadow [1:NUM_ELEMENTS];
    logic [SUM_W-1:0] expected_sums [$];

    initial fail_count = 0;
    assign pending = expected_sums.size();

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // Sum of the elements that lie inside both the asked range and 1..N.
    function automatic logic [SUM_W-1:0] range_total(input logic [POS_W-1:0] lo,
                                                      input logic [POS_W-1:0] hi);
        logic [SUM_W-1:0] acc;
        int first;
        int last;
        int p;
        acc   = '0;
        first = (lo < 1) ? 1 : int'(lo);
        last  = (hi > NUM_ELEMENTS) ? NUM_ELEMENTS : int'(hi);
        for (p = first; p <= last; p++)
            acc += element_shadow[p];
        return acc;
    endfunction

    always @(posedge aclk) begin
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic [SUM_W-1:0] want;
        if (!aresetn) begin
            for (int p = 1; p <= NUM_ELEMENTS; p++)
                element_shadow[p] = '0;
            expected_sums.delete();
        end else begin
            // Results first: a sum leaving now belongs to an older query.
            if (m_tvalid && m_tready) begin
                if (expected_sums.size() == 0) begin
                    report_mismatch($sformatf("unexpected sum %h", m_tdata[SUM_W-1:0]));
                end else begin
                    want = expected_sums.pop_front();
                    if (m_tdata[SUM_W-1:0] !== want)
                        report_mismatch($sformatf("range_sum got %h want %h",
                                                  m_tdata[SUM_W-1:0], want));
                end
            end
            if (s_tvalid && s_tready) begin
                pos = s_tdata[POS_LSB +: POS_W];
                lo  = s_tdata[LEFT_LSB +: POS_W];
                hi  = s_tdata[RIGHT_LSB +: POS_W];
                if (op_t'(s_tuser[0]) == OP_QUERY) begin
                    expected_sums.push_back((lo > hi) ? '0 : range_total(lo, hi));
                end else if (pos >= 1 && pos <= NUM_ELEMENTS) begin
                    element_shadow[pos] = s_tdata[VAL_LSB +: VAL_W];
                end
            end
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the segment tree range sum core: clock, reset, stimulus
// and verdict. Depends on segtr_pkg, the core and segtr_sum_checker.
`timescale 1ns / 1ps

module tb_top;
    import segtr_pkg::*;

    localparam int NUM_ELEMENTS = 1024;
    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_TAIL   = 150;
    localparam int CYCLE_LIMIT  = 500000;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_ELEMENTS);
    localparam logic [POS_W-1:0] PAST_POS = POS_W'(NUM_ELEMENTS + 1);

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    int   fail_count;
    int   pending;
    logic quiet = 1'b0;
    int   stall_left = 0;
    int   cycle_count = 0;

    segment_tree_range_sum_core #(.NUM_ELEMENTS(NUM_ELEMENTS)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    segtr_sum_checker #(.NUM_ELEMENTS(NUM_ELEMENTS)) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("segment_tree_range_sum_core regression: fail");
            $finish;
        end
    end

    // Receiver back-pressure: stalls of random length, none in the tail.
    always @(posedge aclk) begin
        if (quiet) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_tready   <= 1'b1;
        end
    end

    // Entered and left at a rising edge; returns at the edge of acceptance.
    task automatic send_word(input op_t op, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] value,
                             input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
        logic [S_TDATA_W-1:0] word;
        int gap;
        word = '0;
        word[POS_LSB +: POS_W]   = pos;
        word[VAL_LSB +: VAL_W]   = value;
        word[LEFT_LSB +: POS_W]  = lo;
        word[RIGHT_LSB +: POS_W] = hi;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Unused fields carry random junk, which the block must ignore.
    task automatic send_set(input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] value);
        send_word(OP_SET, pos, value, POS_W'($urandom), POS_W'($urandom));
    endtask

    task automatic send_query(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
        send_word(OP_QUERY, POS_W'($urandom), {$urandom, $urandom}, lo, hi);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] v;
        int s;
        case ($urandom_range(0, 7))
            0: v = 64'h7FFF_FFFF_FFFF_FFFF;
            1: v = 64'h8000_0000_0000_0000;
            2: v = '1;
            3, 4: begin
                s = int'($urandom_range(0, 200)) - 100;
                v = VAL_W'(s);
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Mostly legal positions, clustered so that elements get overwritten.
    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? '0 : POS_W'($urandom_range(1025, 2047));
            1, 2:    return POS_W'($urandom_range(1, 8));
            3:       return POS_W'($urandom_range(1017, NUM_ELEMENTS));
            4:       return POS_W'($urandom_range(509, 516));
            default: return POS_W'($urandom_range(1, NUM_ELEMENTS));
        endcase
    endfunction

    task automatic send_random_query();
        logic [POS_W-1:0] a;
        logic [POS_W-1:0] b;
        case ($urandom_range(0, 9))
            0: begin
                // Left past right.
                a = POS_W'($urandom_range(2, NUM_ELEMENTS));
                b = POS_W'($urandom_range(1, a - 1));
                send_query(a, b);
            end
            1: send_query(POS_W'($urandom), POS_W'($urandom));
            2: begin
                a = POS_W'($urandom_range(1, NUM_ELEMENTS));
                send_query(a, a);
            end
            3: send_query(POS_W'($urandom_range(0, 16)), POS_W'($urandom_range(0, 16)));
            default: begin
                a = POS_W'($urandom_range(1, NUM_ELEMENTS));
                b = POS_W'($urandom_range(a, NUM_ELEMENTS));
                send_query(a, b);
            end
        endcase
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: cleared store, extremes, wrap, out-of-range cases.
        send_query(11'd1, LAST_POS);
        send_set(11'd1, 64'h7FFF_FFFF_FFFF_FFFF);
        send_set(11'd2, 64'h7FFF_FFFF_FFFF_FFFF);
        send_set(LAST_POS, 64'h8000_0000_0000_0000);
        send_set(11'd0, 64'h1234_5678_9ABC_DEF0);
        send_set(PAST_POS, '1);
        send_set(11'h7FF, '1);
        send_query(11'd1, 11'd2);
        send_query(11'd1, LAST_POS);
        send_query(LAST_POS, LAST_POS);
        send_query(11'd0, 11'd0);
        send_query(11'd0, 11'h7FF);
        send_query(PAST_POS, 11'h7FF);
        send_query(11'h7FF, 11'h7FF);
        send_query(11'd5, 11'd3);
        send_query(LAST_POS, 11'd1);
        send_set(11'd512, '1);
        send_set(11'd513, 64'h0000_0000_0000_0002);
        send_query(11'd512, 11'd513);
        send_query(11'd511, 11'd512);
        send_set(11'd1, '0);
        send_query(11'd1, 11'd1);
        send_set(11'd2, 64'h5555_5555_5555_5555);
        send_set(LAST_POS, 64'hAAAA_AAAA_AAAA_AAAA);
        send_query(11'd0, LAST_POS);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2)
                wait_for_results();
            if (i == RANDOM_ITEMS - QUIET_TAIL)
                quiet <= 1'b1;
            if ($urandom_range(0, 1) == 0)
                send_set(pick_position(), pick_value());
            else
                send_random_query();
        end

        wait_for_results();
        repeat (40) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("segment_tree_range_sum_core regression: pass");
        end else begin
            $display("segment_tree_range_sum_core regression: fail");
        end
        $finish;
    end

endmodule
